// ===== rtl/core/bsa_pkg.sv =====
// Shared constants, codes and types for the bitmap slot allocator.
package bsa_pkg;

	localparam int CMD_W      = 3;
	localparam int IDX_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = 9;
	localparam int INDEX_SPAN = 256;

	localparam int DEF_SLOT_COUNT = 256;
	localparam int DEF_WORD_BITS  = 32;

	localparam logic [CNT_W-1:0] BITS_IN_USE_RESET = 9'd256;

	localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEST    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ALL_SET = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ALL_CLR = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

	typedef struct packed {
		logic any_free;
		logic any_set;
		logic last;
		logic hit;
		logic bit_val;
	} bsa_word_flags_t;

endpackage

// ===== rtl/core/bsa_cmd_if.sv =====
// Command channel interface of the bitmap slot allocator.
interface bsa_cmd_if
	import bsa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [IDX_W-1:0]  bit_index;

	modport source (output valid, output command, output bit_index, input ready);
	modport sink (input valid, input command, input bit_index, output ready);
endinterface

// ===== rtl/core/bsa_rsp_if.sv =====
// Response channel interface of the bitmap slot allocator.
interface bsa_rsp_if
	import bsa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                bit_value;
	logic [IDX_W-1:0]    found_index;
	logic [CNT_W-1:0]    set_count;

	modport source (output valid, output status, output bit_value, output found_index,
		output set_count, input ready);
	modport sink (input valid, input status, input bit_value, input found_index,
		input set_count, output ready);
endinterface

// ===== rtl/core/bsa_word_unit.sv =====
// Shared word unit: valid mask, first free slot, population count and bit update.
module bsa_word_unit
	import bsa_pkg::*;
#(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int BASE_W    = 9
) (
	input  logic [WORD_BITS-1:0]          word,
	input  logic [BASE_W-1:0]             base,
	input  logic [CNT_W-1:0]              n_valid,
	input  logic [IDX_W-1:0]              bit_index,
	input  logic [CMD_W-1:0]              command,
	output logic [WORD_BITS-1:0]          new_word,
	output logic [$clog2(WORD_BITS)-1:0]  free_pos,
	output logic [$clog2(WORD_BITS+1)-1:0] popcount,
	output bsa_word_flags_t               flags
);
	localparam int CMP_W  = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;
	localparam int POS_W  = $clog2(WORD_BITS);
	localparam int POPC_W = $clog2(WORD_BITS + 1);

	logic [CMP_W-1:0]     base_ext;
	logic [CMP_W-1:0]     n_ext;
	logic [CMP_W-1:0]     idx_ext;
	logic [CMP_W-1:0]     top_ext;
	logic [CMP_W-1:0]     offset_ext;
	logic [POS_W-1:0]     offset;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] used_bits;
	logic [WORD_BITS-1:0] bit_sel;
	logic [WORD_BITS-1:0] free_sel;

	assign base_ext   = CMP_W'(base);
	assign n_ext      = CMP_W'(n_valid);
	assign idx_ext    = CMP_W'(bit_index);
	assign top_ext    = base_ext + CMP_W'(WORD_BITS);
	assign offset_ext = idx_ext - base_ext;
	assign offset     = offset_ext[POS_W-1:0];

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = (base_ext + CMP_W'(b)) < n_ext;
		end
	end

	assign free_bits = ~word & mask;
	assign used_bits = word & mask;

	always_comb begin
		free_pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				free_pos = POS_W'(b);
			end
		end
	end

	always_comb begin
		popcount = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			popcount = popcount + POPC_W'(used_bits[b]);
		end
	end

	always_comb begin
		flags.any_free = |free_bits;
		flags.any_set  = |used_bits;
		flags.last     = top_ext >= n_ext;
		flags.hit      = (idx_ext >= base_ext) && (idx_ext < top_ext);
		flags.bit_val  = flags.hit ? word[offset] : 1'b0;
	end

	assign bit_sel  = flags.hit ? (WORD_BITS'(1) << offset) : '0;
	assign free_sel = WORD_BITS'(1) << free_pos;

	always_comb begin
		case (command)
			CMD_SET:   new_word = word | bit_sel;
			CMD_CLEAR: new_word = word & ~bit_sel;
			CMD_FIND:  new_word = word | free_sel;
			default:   new_word = word;
		endcase
	end
endmodule

// ===== rtl/core/bitmap_slot_allocator_core.sv =====
// Bitmap slot allocator top level: word memory, command sequencer and response register.
//
// Requests arrive on the cmd channel (valid/ready) and each one yields exactly one
// response on the rsp channel. The map lives in a memory of one word per row and
// is walked one word per cycle by a single shared word unit.
// A request is taken only while the block is idle. Set, clear and test walk the
// words up to the one that holds the slot; find, count, all set and all clear walk
// the valid words until the answer is known. A request passes from acceptance
// through the scan state to the done state, where the response is valid; an
// out-of-range index or an unused command goes straight from idle to the done
// state. The word memory has a single read port.
// The next request can be accepted in the cycle after the response is taken, so
// the block does not take a new request before the previous one is answered.
// The response is held in a register until the receiver takes it; while it waits,
// no new request is accepted.
// After reset the block clears the memory one word per cycle before the first
// request is accepted. bits_in_use resets to 256 and may be written through
// cfg_wr_en / cfg_wr_data whenever no request is in flight.
module bitmap_slot_allocator_core
	import bsa_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int WORD_BITS  = DEF_WORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	bsa_cmd_if.sink          cmd,
	bsa_rsp_if.source        rsp
);
	localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BASE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);
	localparam int POS_W      = $clog2(WORD_BITS);
	localparam int POPC_W     = $clog2(WORD_BITS + 1);
	localparam int LIMIT      = (SLOT_COUNT < INDEX_SPAN) ? SLOT_COUNT : INDEX_SPAN;

	localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORD_COUNT - 1);
	localparam logic [CNT_W-1:0] N_LIMIT   = CNT_W'(LIMIT);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rd_data_q;

	logic [1:0]          state_q;
	logic [WA_W-1:0]     word_q;
	logic [BASE_W-1:0]   base_q;
	logic [CNT_W-1:0]    bits_in_use_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    acc_q;
	logic [STATUS_W-1:0] status_q;
	logic                value_q;
	logic [IDX_W-1:0]    found_q;
	logic [CNT_W-1:0]    count_q;

	logic [CNT_W-1:0]     n_valid;
	logic [WA_W-1:0]      next_word;
	logic [WA_W-1:0]      rd_addr;
	logic                 accept;
	logic                 single_op;
	logic                 out_of_range;
	logic                 unused_cmd;
	logic                 last_word;
	logic [WORD_BITS-1:0] new_word;
	logic [POS_W-1:0]     free_pos;
	logic [POPC_W-1:0]    popcount;
	bsa_word_flags_t      flags;

	logic                 scan_done;
	logic                 scan_we;
	logic [STATUS_W-1:0]  res_status;
	logic                 res_value;
	logic [IDX_W-1:0]     res_found;
	logic [CNT_W-1:0]     res_count;
	logic [CNT_W-1:0]     acc_next;

	assign n_valid   = (bits_in_use_q > N_LIMIT) ? N_LIMIT : bits_in_use_q;
	assign next_word = (word_q == LAST_WORD) ? '0 : word_q + WA_W'(1);
	assign rd_addr   = (state_q == ST_SCAN) ? next_word : '0;

	assign cmd.ready    = (state_q == ST_IDLE);
	assign accept       = cmd.valid && cmd.ready;
	assign single_op    = (cmd.command == CMD_SET) || (cmd.command == CMD_CLEAR) ||
		(cmd.command == CMD_TEST);
	assign out_of_range = single_op && (CNT_W'(cmd.bit_index) >= n_valid);
	assign unused_cmd   = cmd.command > CMD_ALL_CLR;

	bsa_word_unit #(
		.WORD_BITS (WORD_BITS),
		.BASE_W    (BASE_W)
	) u_word_unit (
		.word      (rd_data_q),
		.base      (base_q),
		.n_valid   (n_valid),
		.bit_index (idx_q),
		.command   (cmd_q),
		.new_word  (new_word),
		.free_pos  (free_pos),
		.popcount  (popcount),
		.flags     (flags)
	);

	assign last_word = flags.last || (word_q == LAST_WORD);
	assign acc_next  = acc_q + CNT_W'(popcount);

	always_comb begin
		scan_done  = 1'b0;
		scan_we    = 1'b0;
		res_status = STATUS_OK;
		res_value  = 1'b0;
		res_found  = '0;
		res_count  = '0;
		case (cmd_q)
			CMD_SET, CMD_CLEAR: begin
				scan_done = flags.hit;
				scan_we   = flags.hit;
			end
			CMD_TEST: begin
				scan_done = flags.hit;
				res_value = flags.bit_val;
			end
			CMD_FIND: begin
				if (flags.any_free) begin
					scan_done = 1'b1;
					scan_we   = 1'b1;
					res_found = IDX_W'(base_q + BASE_W'(free_pos));
				end else if (last_word) begin
					scan_done  = 1'b1;
					res_status = STATUS_NO_FREE;
				end
			end
			CMD_COUNT: begin
				scan_done = last_word;
				res_count = acc_next;
			end
			CMD_ALL_SET: begin
				scan_done = flags.any_free || last_word;
				res_value = !flags.any_free;
			end
			CMD_ALL_CLR: begin
				scan_done = flags.any_set || last_word;
				res_value = !flags.any_set;
			end
			default: begin
				scan_done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[word_q] <= '0;
		end else if ((state_q == ST_SCAN) && scan_we) begin
			mem[word_q] <= new_word;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			word_q        <= '0;
			bits_in_use_q <= BITS_IN_USE_RESET;
		end else begin
			if (cfg_wr_en) begin
				bits_in_use_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					word_q <= next_word;
					if (word_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					word_q <= '0;
					if (accept) begin
						state_q <= (out_of_range || unused_cmd) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DONE;
					end else begin
						word_q <= next_word;
					end
				end
				ST_DONE: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd.command;
			idx_q    <= cmd.bit_index;
			base_q   <= '0;
			acc_q    <= '0;
			status_q <= out_of_range ? STATUS_RANGE : STATUS_OK;
			value_q  <= 1'b0;
			found_q  <= '0;
			count_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			base_q <= base_q + BASE_W'(WORD_BITS);
			acc_q  <= acc_next;
			if (scan_done) begin
				status_q <= res_status;
				value_q  <= res_value;
				found_q  <= res_found;
				count_q  <= res_count;
			end
		end
	end

	assign rsp.valid       = (state_q == ST_DONE);
	assign rsp.status      = status_q;
	assign rsp.bit_value   = value_q;
	assign rsp.found_index = found_q;
	assign rsp.set_count   = count_q;
endmodule

// ===== bench/bsa_alloc_checker.sv =====
// Checker that predicts every response of the bitmap slot allocator and compares it.
`timescale 1ns / 100ps

module bsa_alloc_checker
	import bsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	bsa_cmd_if               cmd,
	bsa_rsp_if               rsp,
	output int               pending,
	output int               mismatches
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                bit_value;
		logic [IDX_W-1:0]    found_index;
		logic [CNT_W-1:0]    set_count;
	} alloc_result_t;

	logic [DEF_SLOT_COUNT-1:0] slot_map;
	logic [CNT_W-1:0]          slots_in_use;
	alloc_result_t             expected_q[$];
	alloc_result_t             seen_rsp;
	int                        error_count = 0;
	int                        rsp_number = 0;

	function automatic int unsigned valid_slot_count();
		int unsigned n;
		n = slots_in_use;
		if (n > DEF_SLOT_COUNT) n = DEF_SLOT_COUNT;
		if (n > INDEX_SPAN) n = INDEX_SPAN;
		return n;
	endfunction

	// Applies one request to the shadow map and returns the response it must produce.
	function automatic alloc_result_t apply_request(input logic [CMD_W-1:0] op,
		input logic [IDX_W-1:0] idx);
		alloc_result_t r;
		int unsigned   n;
		int unsigned   i;
		r = '0;
		n = valid_slot_count();
		case (op)
			CMD_SET, CMD_CLEAR, CMD_TEST: begin
				if (idx >= n) begin
					r.status = STATUS_RANGE;
				end else if (op == CMD_SET) begin
					slot_map[idx] = 1'b1;
				end else if (op == CMD_CLEAR) begin
					slot_map[idx] = 1'b0;
				end else begin
					r.bit_value = slot_map[idx];
				end
			end
			CMD_FIND: begin
				r.status = STATUS_NO_FREE;
				for (i = 0; i < n; i++) begin
					if (!slot_map[i]) begin
						slot_map[i] = 1'b1;
						r.found_index = i[IDX_W-1:0];
						r.status = STATUS_OK;
						break;
					end
				end
			end
			CMD_COUNT: begin
				for (i = 0; i < n; i++) begin
					if (slot_map[i]) r.set_count = r.set_count + 1'b1;
				end
			end
			CMD_ALL_SET: begin
				r.bit_value = 1'b1;
				for (i = 0; i < n; i++) begin
					if (!slot_map[i]) r.bit_value = 1'b0;
				end
			end
			CMD_ALL_CLR: begin
				r.bit_value = 1'b1;
				for (i = 0; i < n; i++) begin
					if (slot_map[i]) r.bit_value = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic compare_response(input alloc_result_t got);
		alloc_result_t want;
		rsp_number++;
		if (expected_q.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: response %0d arrived with no request outstanding", $time,
					rsp_number);
			return;
		end
		want = expected_q.pop_front();
		if (got.status !== want.status || got.bit_value !== want.bit_value ||
			got.found_index !== want.found_index || got.set_count !== want.set_count) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: rsp %0d exp st=%0d v=%0d i=%0d c=%0d, got st=%0d v=%0d i=%0d c=%0d",
					$time, rsp_number, want.status, want.bit_value, want.found_index,
					want.set_count, got.status, got.bit_value, got.found_index,
					got.set_count);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			slot_map = '0;
			slots_in_use = BITS_IN_USE_RESET;
			expected_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen_rsp.status = rsp.status;
				seen_rsp.bit_value = rsp.bit_value;
				seen_rsp.found_index = rsp.found_index;
				seen_rsp.set_count = rsp.set_count;
				compare_response(seen_rsp);
			end
			if (cmd.valid && cmd.ready)
				expected_q.push_back(apply_request(cmd.command, cmd.bit_index));
			if (cfg_wr_en) slots_in_use = cfg_wr_data;
		end
		pending <= expected_q.size();
		mismatches <= error_count;
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the bitmap slot allocator testbench: clock, reset, requests and the verdict.
`timescale 1ns / 100ps

module tb_top;
	import bsa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam logic [CMD_W-1:0] CMD_ORDER[8] = '{CMD_SET, CMD_CLEAR, CMD_TEST, CMD_FIND,
		CMD_COUNT, CMD_ALL_SET, CMD_ALL_CLR, CMD_UNUSED};
	localparam logic [CNT_W-1:0] PHASE_SLOTS[10] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd37,
		9'd64, 9'd8, 9'd300, 9'd255, 9'd200};
	localparam int CYCLE_LIMIT     = 500000;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int SETTLE_CYCLES   = 12;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	int               send_gap_pct = 0;
	int               recv_stall_pct = 0;
	int               cycle_count = 0;
	int unsigned      slots_live;
	int               pending;
	int               mismatches;
	int               p;

	bsa_cmd_if cmd ();
	bsa_rsp_if rsp ();

	bitmap_slot_allocator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.rsp         (rsp)
	);

	bsa_alloc_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.rsp         (rsp),
		.pending     (pending),
		.mismatches  (mismatches)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** bitmap_slot_allocator_core: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.command   <= op;
		cmd.bit_index <= idx;
		do @(posedge clk); while (!cmd.ready);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slots(input logic [CNT_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		slots_live = (value > INDEX_SPAN) ? INDEX_SPAN : value;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
			3: begin send_gap_pct = 27; recv_stall_pct = 27; end
			default: begin send_gap_pct = 0; recv_stall_pct = 0; end
		endcase
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		int r;
		r = $urandom_range(19);
		if (slots_live == 0 || r == 0) return IDX_W'($urandom_range(255));
		if (r == 1 && slots_live < INDEX_SPAN) return IDX_W'(slots_live);
		return IDX_W'($urandom_range(slots_live - 1));
	endfunction

	// Mix 1 leans toward allocation so the map fills up, mix 2 toward release.
	function automatic logic [CMD_W-1:0] pick_command(input int mix);
		int weight[8];
		int r;
		int acc;
		int k;
		case (mix)
			1: weight = '{15, 3, 10, 45, 9, 9, 6, 3};
			2: weight = '{3, 45, 10, 10, 10, 6, 13, 3};
			default: weight = '{15, 15, 15, 20, 10, 10, 10, 5};
		endcase
		r = $urandom_range(99);
		acc = 0;
		for (k = 0; k < 8; k++) begin
			acc += weight[k];
			if (r < acc) return CMD_ORDER[k];
		end
		return CMD_UNUSED;
	endfunction

	task automatic run_random(input int count);
		int mix;
		int k;
		mix = 0;
		for (k = 0; k < count; k++) begin
			if (k % 30 == 0) mix = $urandom_range(2);
			send_request(pick_command(mix), pick_index());
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= '0;
		cmd.valid     <= 1'b0;
		cmd.command   <= CMD_TEST;
		cmd.bit_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		slots_live = BITS_IN_USE_RESET;

		send_request(CMD_TEST, 8'd0);
		send_request(CMD_SET, 8'd0);
		send_request(CMD_SET, 8'd255);
		send_request(CMD_TEST, 8'd255);
		send_request(CMD_TEST, 8'd0);
		send_request(CMD_FIND, 8'd0);
		send_request(CMD_COUNT, 8'd0);
		send_request(CMD_ALL_SET, 8'd0);
		send_request(CMD_ALL_CLR, 8'd0);
		send_request(CMD_UNUSED, 8'd255);
		send_request(CMD_CLEAR, 8'd0);
		send_request(CMD_FIND, 8'd170);
		send_request(CMD_CLEAR, 8'd255);
		send_request(CMD_CLEAR, 8'd1);
		send_request(CMD_CLEAR, 8'd0);
		send_request(CMD_ALL_CLR, 8'd85);
		drain();

		// With no valid slot every index is out of range and the map counts as full.
		write_slots(9'd0);
		send_request(CMD_FIND, 8'd0);
		send_request(CMD_ALL_SET, 8'd0);
		send_request(CMD_ALL_CLR, 8'd0);
		send_request(CMD_COUNT, 8'd0);
		send_request(CMD_SET, 8'd0);
		drain();

		write_slots(9'd1);
		send_request(CMD_FIND, 8'd0);
		send_request(CMD_FIND, 8'd0);
		send_request(CMD_ALL_SET, 8'd0);
		send_request(CMD_TEST, 8'd1);
		drain();

		for (p = 0; p < 10; p++) begin
			set_idling(p % 4);
			write_slots(PHASE_SLOTS[p]);
			run_random(ITEMS_PER_PHASE);
			drain();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("** bitmap_slot_allocator_core: PASSED **");
		end else begin
			$display("** bitmap_slot_allocator_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bsa_pkg.sv
rtl/core/bsa_cmd_if.sv
rtl/core/bsa_rsp_if.sv
rtl/core/bsa_word_unit.sv
rtl/core/bitmap_slot_allocator_core.sv
bench/bsa_alloc_checker.sv
bench/tb_top.sv
